// File: rtl/spi_byte_bitbang_shifter_unit_assert.svh
// Assertion macros shared by the SPI byte shifter RTL.
`ifndef SPI_BYTE_BITBANG_SHIFTER_UNIT_ASSERT_SVH
`define SPI_BYTE_BITBANG_SHIFTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define SBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define SBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sbb_pkg.sv
// Package with the item types and constants of the SPI byte shifter.
`default_nettype none

package sbb_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd6;
  localparam logic [3:0] BITS_LOAD = 4'(BITS_PER_BYTE);

  // Input item kinds; the fourth code is unused and changes nothing.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_LOAD = 2'd1;
  localparam logic [1:0] KIND_CS   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       cs_level;
  } in_item_t;

  typedef struct packed {
    logic busy_res;
    logic cs_n;
    logic sclk_rise;
    logic sclk;
    logic mosi;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/sbb_in_stage.sv
// Input register of the SPI byte shifter, with its ready logic.
`default_nettype none

module sbb_in_stage
  import sbb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     advance,
  output logic          held_valid,
  output in_item_t      held_item
);

  // A new item enters when the register is empty or drains this cycle.
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sbb_core.sv
// Shifter state, phase_ticks register and the next-state logic for one item.
`default_nettype none

module sbb_core
  import sbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  input  wire logic [7:0] cfg_data,
  input  wire logic       fire,
  input  wire in_item_t   item,
  output out_item_t       result
);

  `include "spi_byte_bitbang_shifter_unit_assert.svh"

  logic [7:0] phase_ticks;
  logic [7:0] shift_byte;
  logic [3:0] bits_left;
  logic       phase_high;
  logic [7:0] divider_count;
  logic       cs_raise_pending;
  logic       mosi;
  logic       sclk;
  logic       cs_n;

  logic [7:0] shift_byte_next;
  logic [3:0] bits_left_next;
  logic       phase_high_next;
  logic [7:0] divider_count_next;
  logic       cs_raise_pending_next;
  logic       mosi_next;
  logic       sclk_next;
  logic       cs_n_next;
  logic       rise;
  logic [7:0] divider_inc;
  logic [2:0] bit_sel;

  // Configuration register; user writes it only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_valid) begin
      phase_ticks <= cfg_data;
    end
  end

  assign divider_inc = divider_count + 8'd1;
  assign bit_sel     = 3'(bits_left - 4'd1);

  // Effect of one item on the shifter and pin state.
  always_comb begin
    shift_byte_next       = shift_byte;
    bits_left_next        = bits_left;
    phase_high_next       = phase_high;
    divider_count_next    = divider_count;
    cs_raise_pending_next = cs_raise_pending;
    mosi_next             = mosi;
    sclk_next             = sclk;
    cs_n_next             = cs_n;
    rise                  = 1'b0;
    unique case (item.kind)
      KIND_TICK: begin
        if (bits_left == 4'd0) begin
          // Idle tick: a held raise request takes effect now.
          if (cs_raise_pending) begin
            cs_raise_pending_next = 1'b0;
            cs_n_next             = 1'b1;
          end
        end else if (divider_inc < phase_ticks) begin
          divider_count_next = divider_inc;
        end else begin
          divider_count_next = 8'd0;
          if (!phase_high) begin
            mosi_next       = shift_byte[bit_sel];
            sclk_next       = 1'b0;
            phase_high_next = 1'b1;
          end else begin
            // Rising edge; the last bit drops the clock in the same step.
            rise            = 1'b1;
            phase_high_next = 1'b0;
            bits_left_next  = bits_left - 4'd1;
            sclk_next       = (bits_left != 4'd1);
          end
        end
      end
      KIND_LOAD: begin
        shift_byte_next    = item.tx_byte;
        bits_left_next     = BITS_LOAD;
        phase_high_next    = 1'b0;
        divider_count_next = 8'd0;
      end
      KIND_CS: begin
        if (!item.cs_level) begin
          cs_raise_pending_next = 1'b0;
          cs_n_next             = 1'b0;
        end else begin
          cs_raise_pending_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // State registers advance once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte       <= 8'd0;
      bits_left        <= 4'd0;
      phase_high       <= 1'b0;
      divider_count    <= 8'd0;
      cs_raise_pending <= 1'b0;
      mosi             <= 1'b0;
      sclk             <= 1'b0;
      cs_n             <= 1'b1;
    end else if (fire) begin
      shift_byte       <= shift_byte_next;
      bits_left        <= bits_left_next;
      phase_high       <= phase_high_next;
      divider_count    <= divider_count_next;
      cs_raise_pending <= cs_raise_pending_next;
      mosi             <= mosi_next;
      sclk             <= sclk_next;
      cs_n             <= cs_n_next;
    end
  end

  // The result shows the levels after this item.
  always_comb begin
    result.mosi      = mosi_next;
    result.sclk      = sclk_next;
    result.sclk_rise = rise;
    result.cs_n      = cs_n_next;
    result.busy_res  = (bits_left_next != 4'd0);
  end

  `SBB_ASSERT_NOW(a_bits_in_range, 1'b1, bits_left <= BITS_LOAD,
    "bit count above one byte")
  `SBB_ASSERT_NOW(a_high_phase_busy, phase_high, bits_left != 4'd0,
    "high phase pending with no bits left")
  `SBB_ASSERT_NOW(a_idle_clock_low, bits_left == 4'd0, !sclk,
    "serial clock high while idle")
  `SBB_ASSERT_NEXT(a_hold_without_item, !fire && !cfg_valid,
    $stable(bits_left) && $stable(divider_count) && $stable(cs_n),
    "state moved with no item processed")

endmodule

`default_nettype wire

// File: rtl/sbb_out_stage.sv
// Result register of the SPI byte shifter.
`default_nettype none

module sbb_out_stage
  import sbb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load_valid,
  input  wire out_item_t load_item,
  output logic           advance,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // The register takes a new result when empty or when its item leaves.
  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      out_item <= load_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/spi_byte_bitbang_shifter_unit.sv
// Top level of the SPI mode 0 byte shifter with stream ports.
//
// Each input item (tick, byte load or chip select request) yields exactly one
// result item with the mosi, sclk and cs_n levels after it. One item is taken
// per clock cycle with no gaps while m_axis_tready stays high. An item sits in
// the input register while the shifter state updates. Its result is then
// registered in the output register and offered on the master side. When the
// sink holds m_axis_tready low, two items are held, one in each register,
// before s_axis_tready drops. phase_ticks resets to 6.
// A cfg write is taken only while the input register is empty, so it applies
// from the next accepted item on.
`default_nettype none

module spi_byte_bitbang_shifter_unit
  import sbb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: phase_ticks.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [7:0] tx_byte, [8] cs_level, rest zero
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // [0] mosi, [1] sclk, [2] sclk_rise,
                                          // [3] cs_n, [4] busy_res, rest zero
);

  `include "spi_byte_bitbang_shifter_unit_assert.svh"

  in_item_t  in_item;
  in_item_t  held_item;
  logic      held_valid;
  logic      advance;
  logic      fire;
  logic      cfg_write;
  out_item_t result;
  out_item_t out_item;

  // The register is written only when no accepted item waits to be processed.
  assign cfg_ready = !held_valid;
  assign cfg_write = cfg_valid && cfg_ready;

  // Unpack the stream payload.
  always_comb begin
    in_item.kind     = s_axis_tuser;
    in_item.tx_byte  = s_axis_tdata[7:0];
    in_item.cs_level = s_axis_tdata[8];
  end

  sbb_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  assign fire = held_valid && advance;

  sbb_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_write),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (held_item),
    .result    (result)
  );

  sbb_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (fire),
    .load_item  (result),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_item   (out_item)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {3'b000, out_item.busy_res, out_item.cs_n,
                         out_item.sclk_rise, out_item.sclk, out_item.mosi};

  `SBB_ASSERT_NOW(a_rise_clock_level, m_axis_tvalid && out_item.sclk_rise,
    out_item.sclk == out_item.busy_res, "clock level wrong after a rising edge")
  `SBB_ASSERT_NOW(a_idle_result_low, m_axis_tvalid && !out_item.busy_res,
    !out_item.sclk, "idle result shows the clock high")
  `SBB_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid,
    "processed item did not reach the result register")

endmodule

`default_nettype wire
